// ----- rtl/slsi_pkg.sv -----
// Package with shared constants and types for the sphere level set block.
package slsi_pkg;

  localparam int INDEX_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int BAND_CELLS     = 6;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 32;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RADIUS  = 3'd0,
    REG_OFF_X   = 3'd1,
    REG_OFF_Y   = 3'd2,
    REG_OFF_Z   = 3'd3,
    REG_CELL_X  = 3'd4,
    REG_CELL_Y  = 3'd5,
    REG_CELL_Z  = 3'd6,
    REG_MODE    = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_SPHERE = 2'd0,
    MODE_CYL_XY = 2'd1,
    MODE_CYL_YZ = 2'd2,
    MODE_CYL_ZX = 2'd3
  } shape_mode_t;

endpackage

// ----- rtl/slsi_sqrt_pipe.sv -----
// Pipelined integer square root of a 64-bit value, one result bit per stage.
module slsi_sqrt_pipe (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] in_radicand,
  output logic        out_valid,
  output logic [31:0] out_root
);

  // Stage s decides root bit 31-s using a restoring step on the remainder.
  logic        vld_r  [1:32];
  logic [63:0] rem_r  [1:31];
  logic [31:0] root_r [1:32];

  for (genvar s = 0; s < 32; s++) begin : g_stage
    logic        v_i;
    logic [63:0] rem_i;
    logic [31:0] root_i;
    logic [65:0] trial;
    logic [65:0] cur;
    logic        fits;

    if (s == 0) begin : g_head
      assign v_i    = in_valid;
      assign rem_i  = in_radicand;
      assign root_i = '0;
    end else begin : g_body
      assign v_i    = vld_r[s];
      assign rem_i  = rem_r[s];
      assign root_i = root_r[s];
    end

    always_comb begin
      // Trial value (4*root + 1) << 2*(31-s), compared against the remainder.
      trial = ({32'd0, root_i, 2'b01}) << (2 * (31 - s));
      cur   = {2'b00, rem_i};
      fits  = cur >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= v_i;
      end
      if (en) begin
        root_r[s+1] <= {root_i[30:0], fits};
      end
    end

    // The last stage needs no remainder.
    if (s < 31) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s+1] <= fits ? 64'(cur - trial) : rem_i;
        end
      end
    end
  end

  assign out_valid = vld_r[32];
  assign out_root  = root_r[32];

endmodule

// ----- rtl/sphere_level_set_init.sv -----
// Top level: streaming signed distance to a sphere or cylinder, clamped to a band.
//
//  Channel | Direction | Handshake            | Payload
//  in_     | slave     | in_tvalid/in_tready  | in_tdata: index_x, index_y, index_z
//  out_    | master    | out_tvalid/out_tready| out_tdata: level_value
//  cfg_    | write     | cfg_we               | cfg_index, cfg_wdata
//
// One cell enters per cycle while the pipeline advances. Stages: one input
// register, one multiply stage, one stage for |d| capping, one squaring stage,
// one sum stage, 32 square root stages (one root bit each), and the output
// register that subtracts the radius and clamps. Reset is synchronous on rst_n:
// it clears the valid bits, offsets and radius and sets unit cells, sphere mode.
// The pipeline advances only when the output register is free or being drained,
// so an out_tready stall freezes every stage; nothing is lost or repeated.
module sphere_level_set_init #(
  parameter int INDEX_BITS = slsi_pkg::INDEX_BITS_DEF,
  parameter int FRAC_BITS  = slsi_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // index_x [INDEX_BITS-1:0], index_y, index_z, then zero fill to whole bytes
  input  logic [((3*INDEX_BITS+7)/8)*8-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // level_value [31:0]
  output logic [31:0]                        out_tdata,
  input  logic                               cfg_we,
  input  logic [slsi_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [slsi_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int ONE_Q = 1 << FRAC_BITS;
  localparam int PROD_BITS = INDEX_BITS + 31;

  logic [30:0]        radius_r, cell_x_r, cell_y_r, cell_z_r;
  logic signed [31:0] off_x_r, off_y_r, off_z_r;
  slsi_pkg::shape_mode_t mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      off_x_r  <= '0;
      off_y_r  <= '0;
      off_z_r  <= '0;
      cell_x_r <= 31'(ONE_Q);
      cell_y_r <= 31'(ONE_Q);
      cell_z_r <= 31'(ONE_Q);
      mode_r   <= slsi_pkg::MODE_SPHERE;
    end else if (cfg_we) begin
      unique case (slsi_pkg::cfg_reg_t'(cfg_index))
        slsi_pkg::REG_RADIUS: radius_r <= cfg_wdata[30:0];
        slsi_pkg::REG_OFF_X:  off_x_r  <= cfg_wdata;
        slsi_pkg::REG_OFF_Y:  off_y_r  <= cfg_wdata;
        slsi_pkg::REG_OFF_Z:  off_z_r  <= cfg_wdata;
        slsi_pkg::REG_CELL_X: cell_x_r <= cfg_wdata[30:0];
        slsi_pkg::REG_CELL_Y: cell_y_r <= cfg_wdata[30:0];
        slsi_pkg::REG_CELL_Z: cell_z_r <= cfg_wdata[30:0];
        slsi_pkg::REG_MODE:   mode_r   <= slsi_pkg::shape_mode_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  // Global advance: the output register is empty or being taken this cycle.
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Stage 1: capture indexes.
  logic                  s1_v_r;
  logic [INDEX_BITS-1:0] s1_ix_r, s1_iy_r, s1_iz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= in_tvalid;
    if (adv) begin
      s1_ix_r <= in_tdata[INDEX_BITS-1:0];
      s1_iy_r <= in_tdata[2*INDEX_BITS-1:INDEX_BITS];
      s1_iz_r <= in_tdata[3*INDEX_BITS-1:2*INDEX_BITS];
    end
  end

  // Stage 2: index times cell size.
  logic                 s2_v_r;
  logic [PROD_BITS-1:0] s2_px_r, s2_py_r, s2_pz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
    if (adv) begin
      s2_px_r <= PROD_BITS'(s1_ix_r) * PROD_BITS'(cell_x_r);
      s2_py_r <= PROD_BITS'(s1_iy_r) * PROD_BITS'(cell_y_r);
      s2_pz_r <= PROD_BITS'(s1_iz_r) * PROD_BITS'(cell_z_r);
    end
  end

  // Stage 3: subtract offset, take magnitude, cap at 2^32-1.
  function automatic logic [31:0] axis_mag(input logic [PROD_BITS-1:0] p,
                                           input logic signed [31:0] off);
    logic signed [PROD_BITS+1:0] d;
    logic        [PROD_BITS+1:0] m;
    begin
      d = $signed({2'b00, p}) - (PROD_BITS+2)'(off);
      m = d[PROD_BITS+1] ? (PROD_BITS+2)'(-d) : d;
      axis_mag = (m[PROD_BITS+1:32] != '0) ? 32'hFFFF_FFFF : m[31:0];
    end
  endfunction

  logic        s3_v_r;
  logic [31:0] s3_mx_r, s3_my_r, s3_mz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (adv) s3_v_r <= s2_v_r;
    if (adv) begin
      s3_mx_r <= axis_mag(s2_px_r, off_x_r);
      s3_my_r <= axis_mag(s2_py_r, off_y_r);
      s3_mz_r <= axis_mag(s2_pz_r, off_z_r);
    end
  end

  // Stage 4: squares.
  logic        s4_v_r;
  logic [63:0] s4_sx_r, s4_sy_r, s4_sz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (adv) s4_v_r <= s3_v_r;
    if (adv) begin
      s4_sx_r <= 64'(s3_mx_r) * 64'(s3_mx_r);
      s4_sy_r <= 64'(s3_my_r) * 64'(s3_my_r);
      s4_sz_r <= 64'(s3_mz_r) * 64'(s3_mz_r);
    end
  end

  // Stage 5: saturating sum of the chosen axes.
  logic [63:0] a_sel, b_sel, c_sel, rsq_nxt;
  logic [65:0] sum3;
  always_comb begin
    a_sel = s4_sx_r;
    b_sel = s4_sy_r;
    c_sel = s4_sz_r;
    unique case (mode_r)
      slsi_pkg::MODE_SPHERE: ;
      slsi_pkg::MODE_CYL_XY: c_sel = '0;
      slsi_pkg::MODE_CYL_YZ: a_sel = '0;
      slsi_pkg::MODE_CYL_ZX: b_sel = '0;
      default: ;
    endcase
    sum3    = 66'(a_sel) + 66'(b_sel) + 66'(c_sel);
    rsq_nxt = (sum3[65:64] != 2'b00) ? '1 : sum3[63:0];
  end

  logic        s5_v_r;
  logic [63:0] s5_rsq_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (adv) s5_v_r <= s4_v_r;
    if (adv) s5_rsq_r <= rsq_nxt;
  end

  // Square root pipeline.
  logic        sq_v;
  logic [31:0] sq_root;
  slsi_sqrt_pipe u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .in_valid   (s5_v_r),
    .in_radicand(s5_rsq_r),
    .out_valid  (sq_v),
    .out_root   (sq_root)
  );

  // Output stage: subtract radius, clamp to band, saturate to 32 bits.
  logic signed [34:0] sdist, band, val;
  logic [31:0]        lvl_nxt;
  always_comb begin
    sdist = $signed({3'b000, sq_root}) - $signed({4'b0000, radius_r});
    band  = $signed(35'(cell_x_r) * 35'(slsi_pkg::BAND_CELLS));
    if (sdist > band)       val = band;
    else if (sdist < -band) val = -band;
    else                    val = sdist;
    if (val > 35'sd2147483647)       lvl_nxt = 32'h7FFF_FFFF;
    else if (val < -35'sd2147483648) lvl_nxt = 32'h8000_0000;
    else                             lvl_nxt = val[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (adv) out_tvalid <= sq_v;
    if (adv) out_tdata <= lvl_nxt;
  end

  // A held result keeps its value while the sink stalls.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  // Output never leaves the band around zero.
  a_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed({{3{out_tdata[31]}}, out_tdata}) <= band) &&
                   ($signed({{3{out_tdata[31]}}, out_tdata}) >= -band))
    else $error("result outside the band");
  // Stage 1 and stage 5 valid bits load only on advance.
  a_s1: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s1_v_r) && $stable(s5_v_r))
    else $error("pipeline moved during stall");

endmodule

// ----- tb/tb_sphere_level_set_init.sv -----
// Testbench for the sphere and cylinder signed distance block with its narrow band clamp.
`timescale 1ns / 100ps

module tb_sphere_level_set_init;

  localparam int IDX_W     = slsi_pkg::INDEX_BITS_DEF;
  localparam int TDATA_W   = ((3*IDX_W+7)/8)*8;
  localparam int LATENCY   = 38;
  localparam longint LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [slsi_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [slsi_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

  sphere_level_set_init DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the configuration registers, used by the distance predictor.
  logic [30:0] sh_radius;
  logic signed [31:0] sh_off_x, sh_off_y, sh_off_z;
  logic [30:0] sh_cell_x, sh_cell_y, sh_cell_z;
  slsi_pkg::shape_mode_t sh_mode;

  // Expected level values, oldest first.
  logic [31:0] level_q[$];

  int errors = 0;
  longint cycles = 0;
  int idle_in_pct = 0;   // chance per cycle that the sender offers nothing
  int stall_out_pct = 0; // chance per cycle that the receiver stalls
  bit hold_off = 1'b0;   // long receiver hold-off in progress

  // |index * cell size - offset| capped at 2^32-1, as an unsigned magnitude.
  function automatic logic [63:0] axis_mag(logic [IDX_W-1:0] idx, logic [30:0] csize,
                                           logic signed [31:0] off);
    logic signed [63:0] d;
    logic [63:0] m;
    d = $signed(64'(idx) * 64'(csize)) - 64'(off);
    m = d < 0 ? -d : d;
    if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
    return m;
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  // Floor of the square root, one root bit at a time.
  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Predicts the clamped signed distance for one cell.
  function automatic logic [31:0] level_of(logic [IDX_W-1:0] ix, logic [IDX_W-1:0] iy,
                                           logic [IDX_W-1:0] iz);
    logic [63:0] mx, my, mz, sx, sy, sz, rsq;
    logic signed [63:0] sdist, band, v;
    mx = axis_mag(ix, sh_cell_x, sh_off_x);
    my = axis_mag(iy, sh_cell_y, sh_off_y);
    mz = axis_mag(iz, sh_cell_z, sh_off_z);
    sx = mx * mx;
    sy = my * my;
    sz = mz * mz;
    case (sh_mode)
      slsi_pkg::MODE_SPHERE: rsq = sat_sum(sat_sum(sx, sy), sz);
      slsi_pkg::MODE_CYL_XY: rsq = sat_sum(sx, sy);
      slsi_pkg::MODE_CYL_YZ: rsq = sat_sum(sy, sz);
      default:               rsq = sat_sum(sx, sz);
    endcase
    sdist = $signed(floor_root(rsq)) - $signed({33'd0, sh_radius});
    band = $signed({33'd0, sh_cell_x}) * slsi_pkg::BAND_CELLS;
    if (sdist > band) v = band;
    else if (sdist < -band) v = -band;
    else v = sdist;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Register write while the block is idle; the shadow copy follows it.
  task automatic write_reg(slsi_pkg::cfg_reg_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      slsi_pkg::REG_RADIUS: sh_radius = val[30:0];
      slsi_pkg::REG_OFF_X:  sh_off_x = val;
      slsi_pkg::REG_OFF_Y:  sh_off_y = val;
      slsi_pkg::REG_OFF_Z:  sh_off_z = val;
      slsi_pkg::REG_CELL_X: sh_cell_x = val[30:0];
      slsi_pkg::REG_CELL_Y: sh_cell_y = val[30:0];
      slsi_pkg::REG_CELL_Z: sh_cell_z = val[30:0];
      slsi_pkg::REG_MODE:   sh_mode = slsi_pkg::shape_mode_t'(val[1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offers one cell and waits for its beat. When want is given the typed-in
  // value must agree with the predictor too. The valid stays up after the
  // beat; idle cycles and drain() take it down.
  task automatic send_cell(logic [IDX_W-1:0] ix, logic [IDX_W-1:0] iy,
                           logic [IDX_W-1:0] iz, bit has_want = 0, logic [31:0] want = 0);
    logic [31:0] pred;
    while ($urandom_range(99) < idle_in_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    pred = level_of(ix, iy, iz);
    if (has_want && pred !== want) begin
      $display("%0t: table row %h %h %h expected %h, predictor gives %h",
               $time, ix, iy, iz, want, pred);
      errors++;
    end
    in_tvalid <= 1'b1;
    in_tdata <= TDATA_W'({iz, iy, ix});
    do @(posedge clk); while (!in_tready);
    level_q.push_back(pred);
  endtask

  // Stops offering, waits until every expected value has come, then lets the
  // pipe drain.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (level_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Receiver: random stalls, and a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !hold_off && ($urandom_range(99) >= stall_out_pct);
  end

  // Checks each result beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (level_q.size() == 0) begin
        $display("%0t: level_value %h arrived with nothing expected", $time, out_tdata);
        errors++;
      end else begin
        logic [31:0] exp_v;
        exp_v = level_q.pop_front();
        if (out_tdata !== exp_v) begin
          $display("%0t: level_value expected %h actual %h", $time, exp_v, out_tdata);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[sphere_level_set_init] ERROR");
      $finish;
    end
  end

  typedef struct {
    logic [IDX_W-1:0] ix, iy, iz;
    bit               has_want;
    logic [31:0]      want;
  } cell_row_t;

  function automatic cell_row_t mk_row(logic [IDX_W-1:0] ix, logic [IDX_W-1:0] iy,
                                       logic [IDX_W-1:0] iz, bit has_want,
                                       logic [31:0] want);
    cell_row_t r;
    r.ix = ix;
    r.iy = iy;
    r.iz = iz;
    r.has_want = has_want;
    r.want = want;
    return r;
  endfunction

  // Random cells: mostly small index values near the surface, some full range.
  task automatic random_cells(int n);
    logic [IDX_W-1:0] ix, iy, iz;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(3) == 0) begin
        ix = IDX_W'($urandom); iy = IDX_W'($urandom); iz = IDX_W'($urandom);
      end else begin
        ix = IDX_W'($urandom_range(63));
        iy = IDX_W'($urandom_range(63));
        iz = IDX_W'($urandom_range(63));
      end
      send_cell(ix, iy, iz);
    end
  endtask

  // Random configuration: a radius and centers that put the surface inside the
  // small index range, or wide random values now and then.
  task automatic random_config();
    bit wide;
    wide = ($urandom_range(4) == 0);
    write_reg(slsi_pkg::REG_CELL_X, wide ? $urandom : $urandom_range(32'h2_0000, 32'h2000));
    write_reg(slsi_pkg::REG_CELL_Y, wide ? $urandom : $urandom_range(32'h2_0000, 32'h2000));
    write_reg(slsi_pkg::REG_CELL_Z, wide ? $urandom : $urandom_range(32'h2_0000, 32'h2000));
    write_reg(slsi_pkg::REG_OFF_X, wide ? $urandom : $urandom_range(32'h40_0000));
    write_reg(slsi_pkg::REG_OFF_Y, wide ? $urandom : $urandom_range(32'h40_0000));
    write_reg(slsi_pkg::REG_OFF_Z, wide ? $urandom : $urandom_range(32'h40_0000));
    write_reg(slsi_pkg::REG_RADIUS, wide ? $urandom : $urandom_range(32'h40_0000));
    write_reg(slsi_pkg::REG_MODE, $urandom_range(3));
  endtask

  initial begin
    cell_row_t rows[$];
    sh_radius = 0; sh_off_x = 0; sh_off_y = 0; sh_off_z = 0;
    sh_cell_x = 31'h1_0000; sh_cell_y = 31'h1_0000; sh_cell_z = 31'h1_0000;
    sh_mode = slsi_pkg::MODE_SPHERE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: unit cells, center at origin, radius zero, sphere.
    // Band is six cells, so distances beyond 6.0 clamp to 0x60000.
    rows.push_back(mk_row(12'd0, 12'd0, 12'd0, 1'b1, 32'h0));
    rows.push_back(mk_row(12'd1, 12'd0, 12'd0, 1'b1, 32'h1_0000));
    rows.push_back(mk_row(12'd0, 12'd2, 12'd0, 1'b1, 32'h2_0000));
    rows.push_back(mk_row(12'd0, 12'd0, 12'd3, 1'b1, 32'h3_0000));
    rows.push_back(mk_row(12'd6, 12'd0, 12'd0, 1'b1, 32'h6_0000));
    rows.push_back(mk_row(12'd7, 12'd0, 12'd0, 1'b1, 32'h6_0000));
    rows.push_back(mk_row(12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 32'h6_0000));
    rows.push_back(mk_row(12'd3, 12'd4, 12'd0, 1'b1, 32'h5_0000));
    rows.push_back(mk_row(12'd1, 12'd1, 12'd0, 1'b0, 32'h0));
    foreach (rows[r]) send_cell(rows[r].ix, rows[r].iy, rows[r].iz, rows[r].has_want,
                                rows[r].want);
    drain();

    // Radius 10: cells inside, on and outside the surface; the band clamps to minus six cells.
    write_reg(slsi_pkg::REG_RADIUS, 32'hA_0000);
    rows.delete();
    rows.push_back(mk_row(12'd0, 12'd0, 12'd0, 1'b1, 32'hFFFA_0000));
    rows.push_back(mk_row(12'd8, 12'd0, 12'd0, 1'b1, 32'hFFFE_0000));
    rows.push_back(mk_row(12'd10, 12'd0, 12'd0, 1'b1, 32'h0));
    rows.push_back(mk_row(12'd0, 12'd0, 12'd13, 1'b1, 32'h3_0000));
    foreach (rows[r]) send_cell(rows[r].ix, rows[r].iy, rows[r].iz, rows[r].has_want,
                                rows[r].want);
    drain();

    // Each cylinder ignores one axis.
    for (int m = 1; m < 4; m++) begin
      write_reg(slsi_pkg::REG_MODE, m);
      send_cell(12'd0, 12'd0, 12'd20);
      send_cell(12'd20, 12'd0, 12'd0);
      send_cell(12'd0, 12'd20, 12'd0);
      drain();
    end

    // Extremes: negative and positive offsets at the limits, widest cells,
    // and a zero band where everything clamps to zero.
    write_reg(slsi_pkg::REG_MODE, slsi_pkg::MODE_SPHERE);
    write_reg(slsi_pkg::REG_OFF_X, 32'h8000_0000);
    write_reg(slsi_pkg::REG_OFF_Y, 32'h7FFF_FFFF);
    write_reg(slsi_pkg::REG_OFF_Z, 32'hFFFF_FFFF);
    write_reg(slsi_pkg::REG_CELL_Y, 32'h7FFF_FFFF);
    write_reg(slsi_pkg::REG_CELL_Z, 32'h0);
    write_reg(slsi_pkg::REG_RADIUS, 32'h7FFF_FFFF);
    write_reg(slsi_pkg::REG_CELL_X, 32'h7FFF_FFFF);
    send_cell(12'hFFF, 12'hFFF, 12'hFFF);
    send_cell(12'd0, 12'd0, 12'd0);
    send_cell(12'd0, 12'hFFF, 12'd5);
    drain();
    write_reg(slsi_pkg::REG_RADIUS, 32'h0);
    send_cell(12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 32'h7FFF_FFFF);
    drain();
    write_reg(slsi_pkg::REG_CELL_X, 32'h0);
    send_cell(12'hABC, 12'h543, 12'h0F0, 1'b1, 32'h0);
    drain();

    // Random phases across the idle patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
        1: begin idle_in_pct = 45; stall_out_pct = 0;  end
        2: begin idle_in_pct = 0;  stall_out_pct = 45; end
        default: begin idle_in_pct = 20; stall_out_pct = 20; end
      endcase
      random_config();
      random_cells(180);
      drain();
    end

    // The receiver holds off for a long stretch while cells keep coming, so
    // the pipeline fills and in_tready drops.
    idle_in_pct = 0;
    stall_out_pct = 0;
    random_config();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      random_cells(90);
    join
    drain();

    if (errors == 0) begin
      $display("[sphere_level_set_init] OK");
    end else begin
      $display("[sphere_level_set_init] ERROR");
    end
    $finish;
  end

endmodule
